/* hdl/assert_macros.svh */
// Assertion helpers for the RTL files; included by zssd_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* hdl/zssd_pkg.sv */
`default_nettype none

package zssd_pkg;

    localparam int INDEX_BITS = 16;

    localparam int ROW_W   = 7;
    localparam int PAD_W   = 9;
    localparam int TB_W    = 10;
    localparam int START_W = 9;
    localparam int LEN_W   = 5;
    localparam int IDX_W   = 16;
    localparam int WORD_W  = 16;

    localparam logic [ROW_W-1:0] ROW_RST       = 7'd1;
    localparam logic [PAD_W-1:0] PAD_RST       = 9'd1;
    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = 7'd45;
    localparam logic [PAD_W-1:0] PAD_LIMIT_RST = 9'd182;
    localparam logic [7:0]       END_PAD       = 8'hFF;

    // configuration register indexes
    localparam logic CFG_ROW_LIMIT = 1'b0;
    localparam logic CFG_PAD_LIMIT = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row_limit;
        logic [PAD_W-1:0] pad_limit;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [PAD_W-1:0] pad;
        logic [TB_W-1:0]  timebin;
        logic [IDX_W-1:0] adc_index;
        logic             bad;
        logic             last;
    } t_hit;

endpackage

`default_nettype wire

/* hdl/zssd_range_chk.sv */
`default_nettype none

module zssd_range_chk (
    input  wire zssd_pkg::t_cfg               i_cfg,
    input  wire logic [zssd_pkg::ROW_W-1:0]   i_row,
    input  wire logic [zssd_pkg::PAD_W-1:0]   i_pad,
    output logic                              o_bad
);

    // zero row or pad counts as out of range too
    assign o_bad = (i_row == '0) || (i_row > i_cfg.row_limit) ||
                   (i_pad == '0) || (i_pad > i_cfg.pad_limit);

endmodule

`default_nettype wire

/* hdl/zssd_seq.sv */
`default_nettype none
`include "assert_macros.svh"

module zssd_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire zssd_pkg::t_cfg                i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_bank_start,
    input  wire logic [zssd_pkg::WORD_W-1:0]   i_seq_word,
    input  wire logic                          i_out_free,
    output logic                               o_hit_valid,
    output zssd_pkg::t_hit                     o_hit
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                                      r_state, n_state;
    logic [zssd_pkg::ROW_W-1:0]                  r_row, n_row;
    logic [zssd_pkg::PAD_W-1:0]                  r_pad, n_pad;
    logic [zssd_pkg::INDEX_BITS-1:0]             r_cnt, n_cnt;
    logic                                        r_ended, n_ended;
    logic [zssd_pkg::TB_W-1:0]                   r_tb, n_tb;
    logic [zssd_pkg::LEN_W-1:0]                  r_left, n_left;
    logic                                        r_bad, n_bad;
    logic                                        r_adv, n_adv;

    logic                                        w_hdr;
    logic [zssd_pkg::ROW_W-1:0]                  w_hdr_row;
    logic [7:0]                                  w_hdr_pad;
    logic                                        w_last;
    logic [zssd_pkg::LEN_W-1:0]                  w_len;
    logic [zssd_pkg::START_W-1:0]                w_start;

    logic [zssd_pkg::ROW_W-1:0]                  e_row;
    logic [zssd_pkg::PAD_W-1:0]                  e_pad;
    logic [zssd_pkg::INDEX_BITS-1:0]             e_cnt;
    logic                                        e_ended;
    logic                                        e_bad;
    logic [zssd_pkg::INDEX_BITS+zssd_pkg::IDX_W-1:0] w_cnt_ext;
    logic                                        w_emit;

    assign w_hdr     = i_seq_word[15];
    assign w_hdr_row = i_seq_word[14:8];
    assign w_hdr_pad = i_seq_word[7:0];
    assign w_last    = i_seq_word[5];
    assign w_len     = i_seq_word[4:0];
    assign w_start   = i_seq_word[14:6];

    // state as seen by this word once a bank start is applied
    assign e_row   = i_bank_start ? zssd_pkg::ROW_RST : r_row;
    assign e_pad   = i_bank_start ? zssd_pkg::PAD_RST : r_pad;
    assign e_cnt   = i_bank_start ? '0 : r_cnt;
    assign e_ended = i_bank_start ? 1'b0 : r_ended;

    zssd_range_chk u_range_chk (
        .i_cfg (i_cfg),
        .i_row (e_row),
        .i_pad (e_pad),
        .o_bad (e_bad)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_emit      = (r_state == S_RUN) && i_out_free;
    assign o_hit_valid = w_emit;

    assign w_cnt_ext = {{zssd_pkg::IDX_W{1'b0}}, r_cnt};

    always_comb begin
        o_hit.row       = r_row;
        o_hit.pad       = r_pad;
        o_hit.timebin   = r_tb;
        o_hit.adc_index = w_cnt_ext[zssd_pkg::IDX_W-1:0];
        o_hit.bad       = r_bad;
        o_hit.last      = (r_left == zssd_pkg::LEN_W'(1));
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_pad   = r_pad;
        n_cnt   = r_cnt;
        n_ended = r_ended;
        n_tb    = r_tb;
        n_left  = r_left;
        n_bad   = r_bad;
        n_adv   = r_adv;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_row   = e_row;
                    n_pad   = e_pad;
                    n_cnt   = e_cnt;
                    n_ended = e_ended;
                    if (!e_ended) begin
                        if (w_hdr) begin
                            n_row = w_hdr_row;
                            n_pad = {1'b0, w_hdr_pad};
                            if (w_hdr_pad == zssd_pkg::END_PAD) begin
                                n_ended = 1'b1;
                            end
                        end else if (w_len == '0) begin
                            // empty run with its last flag set still moves to the next pad
                            if (w_last) begin
                                n_pad = e_pad + zssd_pkg::PAD_W'(1);
                            end
                        end else begin
                            n_tb    = {1'b0, w_start};
                            n_left  = w_len;
                            n_bad   = e_bad;
                            n_adv   = w_last;
                            n_state = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (w_emit) begin
                    n_tb   = r_tb + zssd_pkg::TB_W'(1);
                    n_left = r_left - zssd_pkg::LEN_W'(1);
                    // saturate the byte index at all ones
                    if (r_cnt != {zssd_pkg::INDEX_BITS{1'b1}}) begin
                        n_cnt = r_cnt + zssd_pkg::INDEX_BITS'(1);
                    end
                    if (r_left == zssd_pkg::LEN_W'(1)) begin
                        n_state = S_IDLE;
                        if (r_adv) begin
                            n_pad = r_pad + zssd_pkg::PAD_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= zssd_pkg::ROW_RST;
            r_pad   <= zssd_pkg::PAD_RST;
            r_cnt   <= '0;
            r_ended <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_pad   <= n_pad;
            r_cnt   <= n_cnt;
            r_ended <= n_ended;
            r_left  <= n_left;
        end
        r_tb  <= n_tb;
        r_bad <= n_bad;
        r_adv <= n_adv;
    end

    `ASSERT_CLK(a_run_has_hits, i_clk, i_rst_n,
        (r_state == S_RUN) |-> (r_left != '0))
    `ASSERT_CLK(a_last_ends_run, i_clk, i_rst_n,
        (w_emit && o_hit.last) |=> (r_state == S_IDLE))
    `ASSERT_CLK(a_ended_holds, i_clk, i_rst_n,
        (o_in_ready && i_in_valid && r_ended && !i_bank_start) |=>
        ($stable(r_row) && $stable(r_pad) && $stable(r_cnt) && (r_state == S_IDLE)))
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n,
        ((r_state == S_RUN) && !i_out_free) |=> ($stable(r_left) && $stable(r_cnt)))

endmodule

`default_nettype wire

/* hdl/zero_suppressed_sequence_decoder_top.sv */
// Zero-suppressed sequence decoder.
// Input stream: one 16-bit sequence word per transaction on s_axis_tdata, with
// s_axis_tuser set on the first word of a bank (clears row, pad, index, end mark).
// Output stream: one hit per transaction; tlast marks the final hit of a run word.
// A header word loads row and pad and gives no output; a run word of length N holds
// the input until its last hit, one hit per cycle through the single timebin/index
// sequencer while the receiver keeps up. The accepted word is registered in the
// sequencer state, then its first hit in the output register that drives m_axis.
// s_axis_tready is high only while no run is in progress. When the receiver stalls,
// the output register holds its hit and the sequencer pauses; nothing is dropped.
// The user must write the limit registers through i_cfg_we / i_cfg_idx / i_cfg_data
// (index 0 row_limit, 1 pad_limit) only while idle; the block does not enforce this.
// Reset (synchronous, active low) sets row and pad to 1, index to 0, clears the
// end mark, empties the output register and restores limits 45 and 182.
`default_nettype none

module zero_suppressed_sequence_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] seq_word
    input  wire logic        s_axis_tuser,   // [0] bank_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [6:0] hit_row, [15:7] hit_pad,
                                             // [25:16] hit_timebin, [41:26] adc_index
    output logic             m_axis_tuser,   // [0] out_of_range
    output logic             m_axis_tlast    // last_in_run
);

    zssd_pkg::t_cfg  r_cfg;
    zssd_pkg::t_hit  w_hit;
    zssd_pkg::t_hit  r_hit;
    logic            r_m_valid;
    logic            w_hit_valid;
    logic            w_out_free;

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_limit <= zssd_pkg::ROW_LIMIT_RST;
            r_cfg.pad_limit <= zssd_pkg::PAD_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                zssd_pkg::CFG_ROW_LIMIT: r_cfg.row_limit <= i_cfg_data[6:0];
                zssd_pkg::CFG_PAD_LIMIT: r_cfg.pad_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    zssd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_bank_start (s_axis_tuser),
        .i_seq_word   (s_axis_tdata),
        .i_out_free   (w_out_free),
        .o_hit_valid  (w_hit_valid),
        .o_hit        (w_hit)
    );

    // output register: load a new hit when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_free) begin
            r_m_valid <= w_hit_valid;
        end
        if (w_out_free && w_hit_valid) begin
            r_hit <= w_hit;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_hit.adc_index, r_hit.timebin, r_hit.pad, r_hit.row};
    assign m_axis_tuser  = r_hit.bad;
    assign m_axis_tlast  = r_hit.last;

endmodule

`default_nettype wire
